>>> rtl/mci_pkg.sv
// shared widths, tables and controller/datapath interface types for the 4x4 inverse
package mci_pkg;

    // fixed-point format and datapath widths
    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int OPER_W    = ELEM_W + 1;
    localparam int PROD_W    = 2 * OPER_W;
    localparam int SUB_W     = 96;
    localparam int ADJ_W     = 128;
    localparam int ACC_W     = 136;
    localparam int DABS_W    = 131;
    localparam int DIV_W     = DABS_W + 1;
    localparam int AABS_W    = 97;
    localparam int NUM_SHIFT = 2 * FRAC_BITS + 1;
    localparam int NUM_W     = AABS_W + NUM_SHIFT + 1;
    localparam int QUO_W     = 33;
    localparam int HI_W      = NUM_W - QUO_W;

    // sequencer counts
    localparam int N_ELEM = 16;
    localparam int N_SUB  = 18;
    localparam int N_ADJ  = 16;

    // mac phases
    typedef enum logic [1:0] {
        PH_SUB = 2'd0,
        PH_ADJ = 2'd1,
        PH_DET = 2'd2
    } t_phase;

    // 2x2 sub-determinant k = m[a]*m[b] - m[c]*m[d]
    localparam logic [3:0] MINOR_TAB [N_SUB][4] = '{
        '{10, 15, 11, 14}, '{9, 15, 11, 13}, '{9, 14, 10, 13},
        '{8, 15, 11, 12},  '{8, 14, 10, 12}, '{8, 13, 9, 12},
        '{6, 15, 7, 14},   '{5, 15, 7, 13},  '{5, 14, 6, 13},
        '{6, 11, 7, 10},   '{5, 11, 7, 9},   '{5, 10, 6, 9},
        '{4, 15, 7, 12},   '{4, 14, 6, 12},  '{4, 11, 7, 8},
        '{4, 10, 6, 8},    '{4, 13, 5, 12},  '{4, 9, 5, 8}
    };

    // adjugate terms: element index and sub-determinant index per term
    localparam logic [3:0] ADJ_EL [N_ADJ][3] = '{
        '{5, 6, 7}, '{1, 2, 3}, '{1, 2, 3}, '{1, 2, 3},
        '{4, 6, 7}, '{0, 2, 3}, '{0, 2, 3}, '{0, 2, 3},
        '{4, 5, 7}, '{0, 1, 3}, '{0, 1, 3}, '{0, 1, 3},
        '{4, 5, 6}, '{0, 1, 2}, '{0, 1, 2}, '{0, 1, 2}
    };

    localparam logic [4:0] ADJ_SUB [N_ADJ][3] = '{
        '{0, 1, 2},  '{0, 1, 2},  '{6, 7, 8},   '{9, 10, 11},
        '{0, 3, 4},  '{0, 3, 4},  '{6, 12, 13}, '{9, 14, 15},
        '{1, 3, 5},  '{1, 3, 5},  '{7, 12, 16}, '{10, 14, 17},
        '{2, 4, 5},  '{2, 4, 5},  '{8, 13, 16}, '{11, 15, 17}
    };

    // bit k set: adjugate entry k is negated
    localparam logic [N_ADJ-1:0] ADJ_NEG = 16'b0101_1010_0101_1010;

    // commands from controller
    typedef struct packed {
        logic       load_en;
        logic [3:0] load_idx;
        logic       mac_en;
        t_phase     phase;
        logic [4:0] k;
        logic [1:0] term;
        logic [1:0] limb;
        logic       first;
        logic       store;
        logic       det_prep;
        logic       abs_en;
        logic       sum_en;
        logic       chk_en;
        logic       div_step;
        logic       emit_en;
        logic       out_last;
    } t_cmd;

    // status back to controller
    typedef struct packed {
        logic pipe_busy;
        logic det_zero;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/matrix4_cofactor_inverse.sv
// top level of the 4x4 adjugate matrix inverse in signed fixed point
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------------------
//  in      | request   | i_in_valid / o_in_ready     | i_element_value
//  out     | result    | o_out_valid / i_out_ready   | o_inverse_value, o_singular,
//          |           |                             | o_saturated, o_last_element
//
// 16 element requests load the matrix, one per cycle. Then one shared 33x33 multiplier
// runs 36 + 144 + 16 multiply-accumulates (18 minors, 16 adjugates, determinant) with
// a drain after each phase until the product stage is empty. Each of the 16 results
// then comes from the one-bit-per-cycle restoring divider; when the matrix is singular
// the division is skipped and each result is emitted directly.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// Input is not taken while a matrix is being processed; a stalled output holds the
// sequencer in place until the result register drains.
module matrix4_cofactor_inverse import mci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ELEM_W-1:0] i_element_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ELEM_W-1:0] o_inverse_value,
    output logic              o_singular,
    output logic              o_saturated,
    output logic              o_last_element
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    mci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic and storage
    mci_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_element_value (i_element_value),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_inverse_value (o_inverse_value),
        .o_singular      (o_singular),
        .o_saturated     (o_saturated),
        .o_last_element  (o_last_element)
    );

endmodule

>>> rtl/mci_ctrl.sv
// sequencer for load, multiply-accumulate phases, serial division and result output
module mci_ctrl import mci_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_LOAD  = 11'b000_0000_0001,
        S_SUB   = 11'b000_0000_0010,
        S_ADJ   = 11'b000_0000_0100,
        S_DET   = 11'b000_0000_1000,
        S_DRAIN = 11'b000_0001_0000,
        S_PREP  = 11'b000_0010_0000,
        S_ABS   = 11'b000_0100_0000,
        S_SUM   = 11'b000_1000_0000,
        S_CHK   = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    t_state     r_next, n_next;
    logic [3:0] r_load, n_load;
    logic [4:0] r_k, n_k;
    logic [1:0] r_term, n_term;
    logic [1:0] r_limb, n_limb;
    logic [5:0] r_cnt, n_cnt;

    // next state and command decode
    always_comb begin
        n_state    = r_state;
        n_next     = r_next;
        n_load     = r_load;
        n_k        = r_k;
        n_term     = r_term;
        n_limb     = r_limb;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd          = '0;
        o_cmd.phase    = PH_SUB;
        o_cmd.load_idx = r_load;
        o_cmd.k        = r_k;
        o_cmd.term     = r_term;
        o_cmd.limb     = r_limb;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_en = 1'b1;
                    n_load = r_load + 4'd1;
                    if (r_load == 4'(N_ELEM - 1)) begin
                        n_state = S_SUB;
                    end
                end
            end
            S_SUB: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.phase  = PH_SUB;
                o_cmd.first  = (r_term == 2'd0);
                o_cmd.store  = (r_term == 2'd1);
                if (r_term == 2'd1) begin
                    n_term = 2'd0;
                    if (r_k == 5'(N_SUB - 1)) begin
                        n_k     = '0;
                        n_next  = S_ADJ;
                        n_state = S_DRAIN;
                    end else begin
                        n_k = r_k + 5'd1;
                    end
                end else begin
                    n_term = 2'd1;
                end
            end
            S_ADJ: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.phase  = PH_ADJ;
                o_cmd.first  = (r_term == 2'd0) && (r_limb == 2'd0);
                o_cmd.store  = (r_term == 2'd2) && (r_limb == 2'd2);
                if (r_limb == 2'd2) begin
                    n_limb = 2'd0;
                    if (r_term == 2'd2) begin
                        n_term = 2'd0;
                        if (r_k == 5'(N_ADJ - 1)) begin
                            n_k     = '0;
                            n_next  = S_DET;
                            n_state = S_DRAIN;
                        end else begin
                            n_k = r_k + 5'd1;
                        end
                    end else begin
                        n_term = r_term + 2'd1;
                    end
                end else begin
                    n_limb = r_limb + 2'd1;
                end
            end
            S_DET: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.phase  = PH_DET;
                o_cmd.first  = (r_term == 2'd0) && (r_limb == 2'd0);
                n_limb = r_limb + 2'd1;
                if (r_limb == 2'd3) begin
                    n_term = r_term + 2'd1;
                    if (r_term == 2'd3) begin
                        n_next  = S_PREP;
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = r_next;
                end
            end
            S_PREP: begin
                o_cmd.det_prep = 1'b1;
                n_state = S_ABS;
            end
            S_ABS: begin
                o_cmd.abs_en = 1'b1;
                n_state = i_stat.det_zero ? S_EMIT : S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk_en = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(QUO_W - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.out_last = (r_k == 5'(N_ADJ - 1));
                if (i_stat.out_free) begin
                    o_cmd.emit_en = 1'b1;
                    if (r_k == 5'(N_ADJ - 1)) begin
                        n_k     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 5'd1;
                        n_state = S_ABS;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_next  <= S_LOAD;
            r_load  <= '0;
            r_k     <= '0;
            r_term  <= '0;
            r_limb  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_load  <= n_load;
            r_k     <= n_k;
            r_term  <= n_term;
            r_limb  <= n_limb;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> rtl/mci_datapath.sv
// matrix store, shared 33x33 multiply-accumulate, serial divider and output register
module mci_datapath import mci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [ELEM_W-1:0] i_element_value,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [ELEM_W-1:0] o_inverse_value,
    output logic              o_singular,
    output logic              o_saturated,
    output logic              o_last_element
);

    // element store, two copies so two elements can be read per cycle
    logic [ELEM_W-1:0] r_mat_a [N_ELEM];
    logic [ELEM_W-1:0] r_mat_b [N_ELEM];
    logic [SUB_W-1:0]  r_sub [N_SUB];
    logic [ADJ_W-1:0]  r_adj [N_ADJ];

    // product stage
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    t_phase                   r_pph;
    logic [4:0]               r_pk;
    logic [1:0]               r_plimb;
    logic                     r_pneg;
    logic                     r_pfirst;
    logic                     r_pstore;

    logic signed [ACC_W-1:0] r_acc, n_acc;

    // division state
    logic [DABS_W-1:0] r_dabs;
    logic              r_dneg;
    logic              r_dzero;
    logic [AABS_W-1:0] r_aabs;
    logic              r_neg;
    logic [NUM_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_nlo;
    logic [QUO_W-1:0]  r_quo;
    logic              r_ovf;

    // output register
    logic              r_ov;
    logic [ELEM_W-1:0] r_val;
    logic              r_sing;
    logic              r_sat;
    logic              r_last;

    logic [3:0]               e_idx;
    logic [3:0]               b_idx;
    logic [ADJ_W-1:0]         wide;
    logic [1:0]               top_limb;
    logic                     op_neg;
    logic [ELEM_W-1:0]        limb_bits;
    logic signed [OPER_W-1:0] opa;
    logic signed [OPER_W-1:0] opb;
    logic signed [PROD_W-1:0] prod;
    logic [4:0]               s_idx;
    logic [SUB_W-1:0]         sub_rd;
    logic [3:0]               adj_addr;
    logic [ADJ_W-1:0]         adj_rd;
    logic [ADJ_W-1:0]         adj_neg;
    logic signed [ACC_W-1:0]  ext;
    logic signed [ACC_W-1:0]  sh;
    logic signed [ACC_W-1:0]  base;
    logic [ACC_W-1:0]         acc_neg;
    logic [DIV_W-1:0]         w_d;
    logic [HI_W-1:0]          hi;
    logic [DIV_W:0]           rem2;
    logic [DIV_W:0]           diff;
    logic                     ge;
    logic [ELEM_W-1:0]        lim;
    logic [ELEM_W-1:0]        qlo;
    logic                     sat;
    logic [ELEM_W-1:0]        val;
    logic                     out_free;

    // adjugate read port: mac phases walk the first column (used by det), else the output index
    assign adj_addr = i_cmd.mac_en ? {i_cmd.term, 2'b00} : i_cmd.k[3:0];
    assign adj_rd   = r_adj[adj_addr];
    assign adj_neg  = '0 - adj_rd;
    assign s_idx    = ADJ_SUB[i_cmd.k[3:0]][i_cmd.term];
    assign sub_rd   = r_sub[s_idx];
    assign b_idx    = MINOR_TAB[i_cmd.k][{i_cmd.term[0], 1'b1}];

    // operand select for the shared multiplier
    always_comb begin
        e_idx    = '0;
        wide     = '0;
        top_limb = 2'd0;
        op_neg   = 1'b0;
        case (i_cmd.phase)
            PH_SUB: begin
                e_idx    = MINOR_TAB[i_cmd.k][{i_cmd.term[0], 1'b0}];
                wide     = {{(ADJ_W - ELEM_W){r_mat_b[b_idx][ELEM_W-1]}}, r_mat_b[b_idx]};
                top_limb = 2'd0;
                op_neg   = i_cmd.term[0];
            end
            PH_ADJ: begin
                e_idx    = ADJ_EL[i_cmd.k[3:0]][i_cmd.term];
                wide     = {{(ADJ_W - SUB_W){sub_rd[SUB_W-1]}}, sub_rd};
                top_limb = 2'd2;
                op_neg   = (i_cmd.term == 2'd1) ^ ADJ_NEG[i_cmd.k[3:0]];
            end
            PH_DET: begin
                e_idx    = {2'b00, i_cmd.term};
                wide     = adj_rd;
                top_limb = 2'd3;
                op_neg   = 1'b0;
            end
            default: begin
                e_idx = '0;
            end
        endcase
        limb_bits = wide[32*i_cmd.limb +: ELEM_W];
        opa = {r_mat_a[e_idx][ELEM_W-1], r_mat_a[e_idx]};
        opb = (i_cmd.limb == top_limb) ? {limb_bits[ELEM_W-1], limb_bits}
                                       : {1'b0, limb_bits};
        prod = opa * opb;
    end

    // accumulate shifted partial product
    always_comb begin
        ext = ACC_W'(r_prod);
        case (r_plimb)
            2'd0:    sh = ext;
            2'd1:    sh = ext <<< 32;
            2'd2:    sh = ext <<< 64;
            default: sh = ext <<< 96;
        endcase
        base  = r_pfirst ? '0 : r_acc;
        n_acc = r_acc;
        if (r_pv) begin
            n_acc = r_pneg ? (base - sh) : (base + sh);
        end
    end

    assign acc_neg = '0 - r_acc;

    // divider step
    assign w_d  = {r_dabs, 1'b0};
    assign hi   = r_num[NUM_W-1:QUO_W];
    assign rem2 = {r_rem, r_nlo[QUO_W-1]};
    assign diff = rem2 - {1'b0, w_d};
    assign ge   = (rem2 >= {1'b0, w_d});

    // result formatting with rounding already folded into the numerator
    always_comb begin
        lim = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qlo = r_quo[ELEM_W-1:0];
        sat = r_ovf | r_quo[QUO_W-1] | (qlo > lim);
        val = sat ? lim : (r_neg ? ('0 - qlo) : qlo);
    end

    assign out_free = !r_ov || i_out_ready;

    // matrix load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_mat_a[i_cmd.load_idx] <= i_element_value;
            r_mat_b[i_cmd.load_idx] <= i_element_value;
        end
    end

    // multiplier stage and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mac_en;
        end
        r_prod   <= prod;
        r_pph    <= i_cmd.phase;
        r_pk     <= i_cmd.k;
        r_plimb  <= i_cmd.limb;
        r_pneg   <= op_neg;
        r_pfirst <= i_cmd.first;
        r_pstore <= i_cmd.store;
        r_acc    <= n_acc;
        if (r_pv && r_pstore) begin
            if (r_pph == PH_SUB) begin
                r_sub[r_pk] <= n_acc[SUB_W-1:0];
            end
            if (r_pph == PH_ADJ) begin
                r_adj[r_pk[3:0]] <= n_acc[ADJ_W-1:0];
            end
        end
    end

    // determinant magnitude, numerator build and restoring division
    always_ff @(posedge i_clk) begin
        if (i_cmd.det_prep) begin
            r_dneg  <= r_acc[ACC_W-1];
            r_dabs  <= r_acc[ACC_W-1] ? acc_neg[DABS_W-1:0] : r_acc[DABS_W-1:0];
            r_dzero <= (r_acc == '0);
        end
        if (i_cmd.abs_en) begin
            r_aabs <= adj_rd[ADJ_W-1] ? adj_neg[AABS_W-1:0] : adj_rd[AABS_W-1:0];
            r_neg  <= adj_rd[ADJ_W-1] ^ r_dneg;
        end
        if (i_cmd.sum_en) begin
            r_num <= (NUM_W'(r_aabs) << NUM_SHIFT) + NUM_W'(r_dabs);
        end
        if (i_cmd.chk_en) begin
            r_ovf <= (DIV_W'(hi) >= w_d);
            r_rem <= DIV_W'(hi);
            r_nlo <= r_num[QUO_W-1:0];
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
            r_nlo <= r_nlo << 1;
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_en) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.emit_en) begin
            r_val  <= r_dzero ? '0 : val;
            r_sing <= r_dzero;
            r_sat  <= r_dzero ? 1'b0 : sat;
            r_last <= i_cmd.out_last;
        end
    end

    assign o_stat.pipe_busy = r_pv;
    assign o_stat.det_zero  = r_dzero;
    assign o_stat.out_free  = out_free;

    assign o_out_valid     = r_ov;
    assign o_inverse_value = r_val;
    assign o_singular      = r_sing;
    assign o_saturated     = r_sat;
    assign o_last_element  = r_last;

endmodule
